/* hw/rtl/mpab_pkg.sv */
package mpab_pkg;

    // quotient bits of the alpha divide and of the per-channel divide
    localparam int AQ_STEPS = 27;
    localparam int CQ_STEPS = 8;

    // pipeline stage positions
    localparam int STG_D   = 3;
    localparam int STG_E   = STG_D + AQ_STEPS + 1;
    localparam int STG_F   = STG_E + 1;
    localparam int STG_OUT = STG_F + CQ_STEPS + 1;
    localparam int NUM_STG = STG_OUT + 1;

    // bt.601 luma weights in q14
    localparam logic [21:0] LUMA_B   = 22'd1868;
    localparam logic [21:0] LUMA_G   = 22'd9617;
    localparam logic [21:0] LUMA_R   = 22'd4899;
    localparam logic [21:0] LUMA_RND = 22'd8192;

    // 2 * 255 * 65536, color numerator scale per tenth of back level
    localparam logic [35:0] COLOR_NUM_SCALE = 36'd33423360;
    localparam logic [26:0] ALPHA_SAT_Q16   = 27'd16711680;

    // values that travel alongside the alpha divide
    typedef struct packed {
        logic        mode;
        logic [10:0] k_b;
        logic [10:0] k_g;
        logic [10:0] k_r;
        logic [7:0]  by;
        logic [8:0]  ga;
    } t_side;

    // result of one channel divide
    typedef struct packed {
        logic       sat;
        logic [7:0] q;
    } t_cq;

endpackage

/* hw/rtl/mpab_qdiv.sv */
module mpab_qdiv
    import mpab_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [35:0] i_num,
    input  logic [31:0] i_dv,
    output t_cq         o_res
);

    logic [31:0] r_rem [0:CQ_STEPS];
    logic [7:0]  r_lo  [0:CQ_STEPS];
    logic [31:0] r_dv  [0:CQ_STEPS];
    logic        r_sat [0:CQ_STEPS];

    logic        sat;

    // quotient of 256 or more saturates, otherwise top bits start below divisor
    assign sat = {4'b0, i_num} >= {i_dv, 8'b0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {4'b0, i_num[35:8]};
            r_lo[0]  <= i_num[7:0];
            r_dv[0]  <= i_dv;
            r_sat[0] <= sat;
        end
    end

    for (genvar j = 1; j <= CQ_STEPS; j++) begin : g_step
        logic [32:0] trial;
        logic        ge;
        logic [32:0] diff;

        assign trial = {r_rem[j-1], r_lo[j-1][7]};
        assign ge    = trial >= {1'b0, r_dv[j-1]};
        assign diff  = trial - {1'b0, r_dv[j-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? diff[31:0] : trial[31:0];
                r_lo[j]  <= {r_lo[j-1][6:0], ge};
                r_dv[j]  <= r_dv[j-1];
                r_sat[j] <= r_sat[j-1];
            end
        end
    end

    assign o_res.sat = r_sat[CQ_STEPS];
    assign o_res.q   = r_lo[CQ_STEPS];

endmodule

/* hw/rtl/mirage_pixel_alpha_blend_core.sv */
// pixel alpha blend: front and back bgr pixel in, one bgra pixel out
// throughput: one item per cycle; a held output stalls the whole pipeline
// reset (sync, active low): pipeline emptied, color mode back to grayscale
module mirage_pixel_alpha_blend_core
    import mpab_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_color_mode,

    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_front_blue,
    input  logic [7:0] i_front_green,
    input  logic [7:0] i_front_red,
    input  logic [7:0] i_back_blue,
    input  logic [7:0] i_back_green,
    input  logic [7:0] i_back_red,

    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_blue,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_alpha
);

    // ---------------------------------------------------------------
    // control: one global advance for all stages, valid bits follow data
    // ---------------------------------------------------------------
    logic               r_color_mode;
    logic [NUM_STG-1:0] r_vld;
    logic               en;

    assign en          = !r_vld[STG_OUT] || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_vld[STG_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= 1'b0;
            r_vld        <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_color_mode <= i_cfg_color_mode;
            end
            if (en) begin
                r_vld <= {r_vld[NUM_STG-2:0], i_in_valid};
            end
        end
    end

    // ---------------------------------------------------------------
    // stage a: scaled channels in tenths, differences, luma of both pixels
    // channel order 0 blue, 1 green, 2 red
    // ---------------------------------------------------------------
    logic [7:0]         fin [0:2];
    logic [7:0]         bin [0:2];
    logic [11:0]        f_s [0:2];
    logic [10:0]        k_s [0:2];
    logic [21:0]        fy_sum;
    logic [21:0]        by_sum;

    logic               r_a_mode;
    logic [10:0]        r_a_k [0:2];
    logic signed [12:0] r_a_d [0:2];
    logic [11:0]        r_a_fr;
    logic [7:0]         r_a_fy;
    logic [7:0]         r_a_by;

    assign fin[0] = i_front_blue;
    assign fin[1] = i_front_green;
    assign fin[2] = i_front_red;
    assign bin[0] = i_back_blue;
    assign bin[1] = i_back_green;
    assign bin[2] = i_back_red;

    for (genvar c = 0; c < 3; c++) begin : g_scale
        assign f_s[c] = 12'(fin[c]) * 12'd12;
        assign k_s[c] = 11'(bin[c]) * 11'd7;
    end

    assign fy_sum = 22'(fin[0]) * LUMA_B + 22'(fin[1]) * LUMA_G
                  + 22'(fin[2]) * LUMA_R + LUMA_RND;
    assign by_sum = 22'(bin[0]) * LUMA_B + 22'(bin[1]) * LUMA_G
                  + 22'(bin[2]) * LUMA_R + LUMA_RND;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_mode <= r_color_mode;
            for (int c = 0; c < 3; c++) begin
                r_a_k[c] <= k_s[c];
                r_a_d[c] <= $signed({2'b0, k_s[c]}) - $signed({1'b0, f_s[c]});
            end
            r_a_fr <= f_s[2];
            r_a_fy <= fy_sum[21:14];
            r_a_by <= by_sum[21:14];
        end
    end

    // ---------------------------------------------------------------
    // stage b: products of the coefficient formula, gray alpha
    // ---------------------------------------------------------------
    logic signed [16:0] lin;
    logic signed [13:0] dd;
    logic signed [13:0] ks_r;
    logic signed [15:0] ca_s;

    logic signed [16:0] r_b_lin;
    logic signed [27:0] r_b_p2;
    logic signed [25:0] r_b_sqr;
    logic signed [25:0] r_b_sqb;
    logic [14:0]        r_b_ca;
    t_side              r_b_side;

    assign lin  = 17'(r_a_d[2]) * 17'sd4 + 17'(r_a_d[1]) * 17'sd8
                + 17'(r_a_d[0]) * 17'sd6;
    assign dd   = 14'(r_a_d[2]) - 14'(r_a_d[0]);
    assign ks_r = $signed({1'b0, 13'(r_a_k[2]) + 13'(r_a_fr)});
    assign ca_s = 16'sd23030 + 16'(r_a_d[2]) - 16'(r_a_d[0]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_lin       <= lin;
            r_b_p2        <= 28'(dd) * 28'(ks_r);
            r_b_sqr       <= 26'(r_a_d[2]) * 26'(r_a_d[2]);
            r_b_sqb       <= 26'(r_a_d[0]) * 26'(r_a_d[0]);
            r_b_ca        <= ca_s[14:0];
            r_b_side.mode <= r_a_mode;
            r_b_side.k_b  <= r_a_k[0];
            r_b_side.k_g  <= r_a_k[1];
            r_b_side.k_r  <= r_a_k[2];
            r_b_side.by   <= r_a_by;
            // back - front + 255 stays in 0..510
            r_b_side.ga   <= 9'(r_a_by) - 9'(r_a_fy) + 9'd255;
        end
    end

    // ---------------------------------------------------------------
    // stage c: alpha numerator n and denominator 40*ca
    // ---------------------------------------------------------------
    logic signed [31:0] r_c_n;
    logic [20:0]        r_c_den;
    t_side              r_c_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_n   <= 32'sd10200 * $signed({17'b0, r_b_ca})
                     + 32'sd5120 * 32'(r_b_lin)
                     + (32'(r_b_p2) <<< 1)
                     + 32'(r_b_sqr) - 32'(r_b_sqb);
            r_c_den <= 21'(r_b_ca) * 21'd40;
            r_c_side <= r_b_side;
        end
    end

    // ---------------------------------------------------------------
    // stage d and 27 steps: aq = round(n * 65536 / den), one bit per stage
    // dividend n*131072 + den over 2*den; the quotient fits in 27 bits
    // ---------------------------------------------------------------
    logic [47:0]        dvd;

    logic [21:0]        r_q_rem  [0:AQ_STEPS];
    logic [26:0]        r_q_lo   [0:AQ_STEPS];
    logic [21:0]        r_q_dv   [0:AQ_STEPS];
    logic               r_q_zero [0:AQ_STEPS];
    t_side              r_q_side [0:AQ_STEPS];

    assign dvd = {1'b0, r_c_n[29:0], 17'b0} + 48'(r_c_den);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q_rem[0]  <= {1'b0, dvd[47:27]};
            r_q_lo[0]   <= dvd[26:0];
            r_q_dv[0]   <= {r_c_den, 1'b0};
            // alpha not positive
            r_q_zero[0] <= r_c_n[31] || (r_c_n == '0);
            r_q_side[0] <= r_c_side;
        end
    end

    for (genvar j = 1; j <= AQ_STEPS; j++) begin : g_aq
        logic [22:0] trial;
        logic        ge;
        logic [22:0] diff;

        assign trial = {r_q_rem[j-1], r_q_lo[j-1][26]};
        assign ge    = trial >= {1'b0, r_q_dv[j-1]};
        assign diff  = trial - {1'b0, r_q_dv[j-1]};

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_q_rem[j]  <= ge ? diff[21:0] : trial[21:0];
                r_q_lo[j]   <= {r_q_lo[j-1][25:0], ge};
                r_q_dv[j]   <= r_q_dv[j-1];
                r_q_zero[j] <= r_q_zero[j-1];
                r_q_side[j] <= r_q_side[j-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // stage e: alpha byte, zero flag, color numerators
    // ---------------------------------------------------------------
    logic [26:0]        aq;
    logic [26:0]        aq_rnd;
    t_side              q_side;

    logic               r_e_zero;
    logic [7:0]         r_e_alpha;
    logic [35:0]        r_e_kx [0:2];
    logic [30:0]        r_e_y10;
    t_side              r_e_side;

    assign aq     = r_q_lo[AQ_STEPS];
    assign aq_rnd = aq + 27'd32768;
    assign q_side = r_q_side[AQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (q_side.mode) begin
                r_e_zero  <= r_q_zero[AQ_STEPS] || (aq == '0);
                r_e_alpha <= (aq >= ALPHA_SAT_Q16) ? 8'd255 : aq_rnd[23:16];
            end else begin
                r_e_zero  <= (q_side.ga == '0);
                r_e_alpha <= q_side.ga[8] ? 8'd255 : q_side.ga[7:0];
            end
            r_e_kx[0] <= 36'(q_side.k_b) * COLOR_NUM_SCALE;
            r_e_kx[1] <= 36'(q_side.k_g) * COLOR_NUM_SCALE;
            r_e_kx[2] <= 36'(q_side.k_r) * COLOR_NUM_SCALE;
            r_e_y10   <= 31'(aq) * 31'd10;
            r_e_side  <= q_side;
        end
    end

    // ---------------------------------------------------------------
    // stage f and 8 steps: per-channel divide, saturating at 255
    // color: (2x + y) / 2y with y = 10*aq; gray: by * 255 / ga
    // ---------------------------------------------------------------
    logic [35:0]        num [0:2];
    logic [31:0]        dv;
    t_cq                cq [0:2];

    logic               r_t_zero  [0:CQ_STEPS];
    logic [7:0]         r_t_alpha [0:CQ_STEPS];

    assign dv = r_e_side.mode ? {r_e_y10, 1'b0} : 32'(r_e_side.ga);

    for (genvar c = 0; c < 3; c++) begin : g_chan
        assign num[c] = r_e_side.mode ? (r_e_kx[c] + 36'(r_e_y10))
                                      : 36'(16'(r_e_side.by) * 16'd255);

        mpab_qdiv u_qdiv (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (num[c]),
            .i_dv  (dv),
            .o_res (cq[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t_zero[0]  <= r_e_zero;
            r_t_alpha[0] <= r_e_alpha;
            for (int j = 1; j <= CQ_STEPS; j++) begin
                r_t_zero[j]  <= r_t_zero[j-1];
                r_t_alpha[j] <= r_t_alpha[j-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    logic [7:0] chan_val [0:2];
    logic [7:0] r_o_chan [0:2];
    logic [7:0] r_o_alpha;

    for (genvar c = 0; c < 3; c++) begin : g_out
        assign chan_val[c] = r_t_zero[CQ_STEPS] ? 8'd0
                           : (cq[c].sat ? 8'd255 : cq[c].q);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r_o_chan[c] <= chan_val[c];
            end
            r_o_alpha <= r_t_zero[CQ_STEPS] ? 8'd0 : r_t_alpha[CQ_STEPS];
        end
    end

    assign o_out_blue  = r_o_chan[0];
    assign o_out_green = r_o_chan[1];
    assign o_out_red   = r_o_chan[2];
    assign o_out_alpha = r_o_alpha;

endmodule

/* dv/tb_mirage_pixel_alpha_blend_core.sv */
module tb_mirage_pixel_alpha_blend_core;

    localparam logic MODE_GRAY  = 1'b0;
    localparam logic MODE_COLOR = 1'b1;
    localparam int   CYCLE_LIMIT = 600000;
    localparam int   DRAIN_WAIT  = 60;

    typedef struct {
        logic [7:0] fb, fg, fr, bb, bg, br;
    } t_pixel;

    typedef struct {
        logic [7:0] blue, green, red, alpha;
    } t_bgra;

    // blend predictor plus queue of pixels still owed by the block
    class t_blend_scoreboard;
        logic   color_mode;
        t_bgra  owed_q[$];
        int     errors;

        function new();
            color_mode = MODE_GRAY;
            errors = 0;
        endfunction

        function longint cap(longint v);
            return (v > 255) ? 255 : v;
        endfunction

        function longint luma(longint b, longint g, longint r);
            return (1868 * b + 9617 * g + 4899 * r + 8192) / 16384;
        endfunction

        function t_bgra blend(t_pixel p);
            t_bgra  o;
            longint f[3], k[3], d[3];
            longint ca, cb, num, den, aq, x, y, fy, by, a, g;
            o = '{8'd0, 8'd0, 8'd0, 8'd0};
            if (color_mode == MODE_COLOR) begin
                f[0] = 12 * p.fb; f[1] = 12 * p.fg; f[2] = 12 * p.fr;
                k[0] = 7 * p.bb;  k[1] = 7 * p.bg;  k[2] = 7 * p.br;
                for (int i = 0; i < 3; i++) d[i] = k[i] - f[i];
                ca  = 23030 + d[2] - d[0];
                cb  = 5120 * (4 * d[2] + 8 * d[1] + 6 * d[0])
                    + 2 * (d[2] - d[0]) * (k[2] + f[2])
                    + d[2] * d[2] - d[0] * d[0];
                num = 10200 * ca + cb;
                den = 40 * ca;
                if (num <= 0) return o;
                aq = (num * 131072 + den) / (2 * den);
                if (aq <= 0) return o;
                o.alpha = (aq >= 255 * 65536) ? 8'd255 : 8'(cap((aq + 32768) / 65536));
                y = 10 * aq;
                x = 255 * 65536 * k[0]; o.blue  = 8'(cap((2 * x + y) / (2 * y)));
                x = 255 * 65536 * k[1]; o.green = 8'(cap((2 * x + y) / (2 * y)));
                x = 255 * 65536 * k[2]; o.red   = 8'(cap((2 * x + y) / (2 * y)));
            end else begin
                fy = luma(p.fb, p.fg, p.fr);
                by = luma(p.bb, p.bg, p.br);
                a  = by - fy + 255;
                g  = (a > 0) ? cap(by * 255 / a) : 0;
                o.blue = 8'(g); o.green = 8'(g); o.red = 8'(g);
                o.alpha = (a > 0) ? 8'(cap(a)) : 8'd0;
            end
            return o;
        endfunction

        function void note_pixel(t_pixel p);
            owed_q.push_back(blend(p));
        endfunction

        function void check_pixel(t_bgra got);
            t_bgra want;
            if (owed_q.size() == 0) begin
                $error("output item with nothing expected");
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.blue !== want.blue) begin
                $error("out_blue exp %0d got %0d", want.blue, got.blue); errors++;
            end
            if (got.green !== want.green) begin
                $error("out_green exp %0d got %0d", want.green, got.green); errors++;
            end
            if (got.red !== want.red) begin
                $error("out_red exp %0d got %0d", want.red, got.red); errors++;
            end
            if (got.alpha !== want.alpha) begin
                $error("out_alpha exp %0d got %0d", want.alpha, got.alpha); errors++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_color_mode;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_front_blue, i_front_green, i_front_red;
    logic [7:0] i_back_blue, i_back_green, i_back_red;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_blue, o_out_green, o_out_red, o_out_alpha;

    t_blend_scoreboard sb;
    bit  no_idle;     // last part of the run: no gaps on either side
    bit  hold_sink;   // request for one long receiver stall
    int  cycles;

    mirage_pixel_alpha_blend_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_color_mode(i_cfg_color_mode),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_front_blue    (i_front_blue),
        .i_front_green   (i_front_green),
        .i_front_red     (i_front_red),
        .i_back_blue     (i_back_blue),
        .i_back_green    (i_back_green),
        .i_back_red      (i_back_red),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_blue      (o_out_blue),
        .o_out_green     (o_out_green),
        .o_out_red       (o_out_red),
        .o_out_alpha     (o_out_alpha)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("mirage_pixel_alpha_blend_core regression: fail");
            $finish;
        end
    end

    // write color_mode while the block is idle
    task automatic write_mode(logic mode);
        @(negedge i_clk);
        i_cfg_valid      = 1'b1;
        i_cfg_color_mode = mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.color_mode = mode;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // offer one pixel, with an optional random gap in front of it
    task automatic send_pixel(t_pixel p);
        int gap;
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            i_in_valid = 1'b0;
            gap = $urandom_range(1, 14);
            repeat (gap) @(negedge i_clk);
        end
        i_front_blue = p.fb; i_front_green = p.fg; i_front_red = p.fr;
        i_back_blue  = p.bb; i_back_green  = p.bg; i_back_red  = p.br;
        i_in_valid   = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_pixel(p);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (sb.owed_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    function automatic logic [7:0] rand_level();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel p;
        p.fb = rand_level(); p.fg = rand_level(); p.fr = rand_level();
        p.bb = rand_level(); p.bg = rand_level(); p.br = rand_level();
        // sometimes a dark back over a bright front, pushing alpha to zero
        if ($urandom_range(0, 9) == 0) begin
            p.bb = 8'($urandom_range(0, 20)); p.bg = 8'($urandom_range(0, 20));
            p.br = 8'($urandom_range(0, 20));
            p.fb = 8'($urandom_range(230, 255)); p.fg = 8'($urandom_range(230, 255));
            p.fr = 8'($urandom_range(230, 255));
        end
        return p;
    endfunction

    task automatic send_directed();
        t_pixel dir_q[$];
        dir_q.push_back('{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0});
        dir_q.push_back('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
        // white front on black back: alpha zero or below
        dir_q.push_back('{8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0});
        // black front on white back: alpha above range
        dir_q.push_back('{8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255});
        dir_q.push_back('{8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd255});
        dir_q.push_back('{8'd0,   8'd0,   8'd255, 8'd255, 8'd0,   8'd0});
        dir_q.push_back('{8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd0});
        dir_q.push_back('{8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128});
        dir_q.push_back('{8'd1,   8'd1,   8'd1,   8'd254, 8'd254, 8'd254});
        dir_q.push_back('{8'd200, 8'd10,  8'd90,  8'd30,  8'd240, 8'd60});
        foreach (dir_q[i]) send_pixel(dir_q[i]);
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++) send_pixel(rand_pixel());
    endtask

    // receiver: random backpressure bursts, one long hold on request
    initial begin
        int stall;
        i_out_ready = 1'b0;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready)
                sb.check_pixel('{o_out_blue, o_out_green, o_out_red, o_out_alpha});
            @(negedge i_clk);
            if (hold_sink) begin
                hold_sink = 1'b0;
                stall = 400;
            end else if (stall == 0 && !no_idle && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 14);
            end
            if (stall > 0) begin
                i_out_ready = 1'b0;
                stall--;
            end else begin
                i_out_ready = i_rst_n;
            end
        end
    end

    initial begin
        sb = new();
        cycles = 0;
        no_idle = 1'b0;
        hold_sink = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_color_mode = MODE_GRAY;
        i_in_valid = 1'b0;
        {i_front_blue, i_front_green, i_front_red} = '0;
        {i_back_blue, i_back_green, i_back_red} = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // gray mode straight out of reset
        send_directed();
        send_random(350);
        wait_drained();

        write_mode(MODE_COLOR);
        send_directed();
        hold_sink = 1'b1;   // sink stalls long while pixels keep coming
        send_random(350);
        wait_drained();     // sender pauses until all results are in
        send_random(150);
        wait_drained();

        write_mode(MODE_GRAY);
        send_random(200);
        wait_drained();

        write_mode(MODE_COLOR);
        no_idle = 1'b1;
        send_random(230);
        wait_drained();

        if (sb.errors == 0)
            $display("mirage_pixel_alpha_blend_core regression: pass");
        else
            $display("mirage_pixel_alpha_blend_core regression: fail");
        $finish;
    end

endmodule
